[rtl/hbcm_pkg.sv]
// hbcm_pkg: request and response types, command and status codes, sequencer states
// for the hashed block cache manager. It has no dependencies.
package hbcm_pkg;

	localparam int BLK_W = 32;
	localparam int DEV_W = 8;
	localparam int CNT_W = 8;
	localparam int TAG_W = DEV_W + BLK_W;

	typedef enum logic [1:0] {
		CMD_GET     = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_PIN     = 2'd2,
		CMD_UNPIN   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_COUNT   = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [DEV_W-1:0]  device_id;
		logic [BLK_W-1:0]  block_number;
		logic [4:0]        buffer_index;
	} req_t;

	typedef struct packed {
		logic [4:0] granted_buffer;
		logic       needs_read;
		status_t    status;
	} rsp_t;

	typedef enum logic [4:0] {
		S_INIT_HEAD,
		S_INIT_BUF0,
		S_INIT_BUF1,
		S_IDLE,
		S_GET_MOD,
		S_HIT_FIRST,
		S_HIT_WALK,
		S_FREE_HEAD,
		S_FREE_FIRST,
		S_FREE_WALK,
		S_BUF_RD,
		S_BUF_CHK,
		S_REL_MOD,
		S_UNLINK,
		S_PUSH_RD,
		S_PUSH_A,
		S_PUSH_B,
		S_RETAG,
		S_DONE
	} state_t;

endpackage

[rtl/hbcm_ram.sv]
// hbcm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module hbcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/hbcm_mod_unit.sv]
// hbcm_mod_unit: remainder of a block number by a constant bucket count, by reciprocal
// multiplication in a quotient phase and then a remainder phase. Uses hbcm_pkg.
module hbcm_mod_unit
	import hbcm_pkg::*;
#(
	parameter int DIVISOR = 8,
	parameter int RW      = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [BLK_W-1:0] dividend,
	output logic             done,
	output logic [RW-1:0]    remainder
);

	// reciprocal of the divisor scaled by 2^(BLK_W + SH), rounded up
	localparam int SH = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
	localparam int MW = BLK_W + 1;
	localparam int PW = BLK_W + MW;
	localparam logic [63:0]    SCALE  = 64'd1 << (BLK_W + SH);
	localparam logic [MW-1:0]  RECIP  = MW'((SCALE + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
	localparam logic [RW-1:0]  DIV_LO = RW'(DIVISOR);

	logic             done_q;
	logic [1:0]       phase_q;
	logic [BLK_W-1:0] x_q;
	logic [BLK_W-1:0] quot_q;
	logic [RW-1:0]    r_q;
	logic [PW-1:0]    prod;

	// quotient estimate: dividend times the scaled reciprocal
	always_comb begin
		prod = {{MW{1'b0}}, x_q} * {{BLK_W{1'b0}}, RECIP};
	end

	// phase 0 forms the quotient, phase 1 the remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			done_q  <= 1'b0;
		end else begin
			phase_q <= {phase_q[0], start};
			done_q  <= phase_q[1];
		end
	end

	// remainder only needs the low bits of dividend minus quotient times divisor
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= dividend;
		end
		if (phase_q[0]) begin
			quot_q <= BLK_W'(prod >> (BLK_W + SH));
		end
		if (phase_q[1]) begin
			r_q <= x_q[RW-1:0] - RW'(quot_q[RW-1:0] * DIV_LO);
		end
	end

	assign done      = done_q;
	assign remainder = r_q;

endmodule

[rtl/hashed_block_cache_manager_core.sv]
// Hashed block cache manager: buffer descriptors in hash buckets, each an LRU ring.
// A get hashes the block number and walks its own ring; on a miss it searches the buckets
// for a free buffer, steals one from another bucket if its own has none, and retags it.
// Pin, unpin and release update the count; a freeing release moves the buffer to its ring head.
// One request at a time: the next can be taken in the same cycle as the response is raised.
// After reset a clearing pass over the bucket heads and then the buffers builds the rings.
module hashed_block_cache_manager_core
	import hbcm_pkg::*;
#(
	parameter int NUM_BUFFERS = 32,
	parameter int NUM_BUCKETS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int NODES = NUM_BUFFERS + NUM_BUCKETS;
	localparam int NW    = $clog2(NODES);
	localparam int BW    = $clog2(NUM_BUFFERS);
	localparam int KW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int CVW   = CNT_W + 1;
	localparam logic [NW-1:0] N_NODE = NW'(NUM_BUFFERS);
	localparam logic [NW-1:0] B_NODE = NW'(NUM_BUCKETS);

	state_t        state_q, state_d;
	req_t          req_q, req_d;
	rsp_t          res_q, res_d, rsp_q, rsp_d;
	logic          rsp_valid_q, rsp_valid_d;
	logic [KW-1:0] bucket_q, bucket_d, scan_q, scan_d, init_k_q, init_k_d;
	logic          steal_q, steal_d;
	logic [NW-1:0] node_q, node_d, link_f_q, link_f_d, link_p_q, link_p_d;
	logic [NW-1:0] first_q, first_d, init_i_q, init_i_d;

	// RAM ports
	logic             tag_we, cnt_we, fwd_we, bwd_we;
	logic [BW-1:0]    tag_waddr, tag_raddr, cnt_waddr, cnt_raddr;
	logic [TAG_W-1:0] tag_wdata, tag_rdata;
	logic [CVW-1:0]   cnt_wdata, cnt_rdata;
	logic [NW-1:0]    fwd_waddr, fwd_raddr, fwd_wdata, fwd_rdata;
	logic [NW-1:0]    bwd_waddr, bwd_raddr, bwd_wdata, bwd_rdata;

	// hash unit
	logic             mod_start, mod_done;
	logic [BLK_W-1:0] mod_x;
	logic [KW-1:0]    mod_rem;

	logic [NW-1:0] head_own, head_scan, head_init, head_rem;
	logic [KW:0]   k_next;
	logic          tag_hit;
	logic [CNT_W-1:0] rc;

	hbcm_ram #(.WIDTH(TAG_W), .DEPTH(NUM_BUFFERS)) u_tag_ram (
		.clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
		.raddr(tag_raddr), .rdata(tag_rdata)
	);

	hbcm_ram #(.WIDTH(CVW), .DEPTH(NUM_BUFFERS)) u_cnt_ram (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	hbcm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fwd_ram (
		.clk(clk), .we(fwd_we), .waddr(fwd_waddr), .wdata(fwd_wdata),
		.raddr(fwd_raddr), .rdata(fwd_rdata)
	);

	hbcm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_bwd_ram (
		.clk(clk), .we(bwd_we), .waddr(bwd_waddr), .wdata(bwd_wdata),
		.raddr(bwd_raddr), .rdata(bwd_rdata)
	);

	hbcm_mod_unit #(.DIVISOR(NUM_BUCKETS), .RW(KW)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .dividend(mod_x),
		.done(mod_done), .remainder(mod_rem)
	);

	assign head_own  = N_NODE + NW'(bucket_q);
	assign head_scan = N_NODE + NW'(scan_q);
	assign head_init = N_NODE + NW'(init_k_q);
	assign head_rem  = N_NODE + NW'(mod_rem);
	assign tag_hit   = (tag_rdata == {req_q.device_id, req_q.block_number});
	assign rc        = cnt_rdata[CNT_W-1:0];

	// next bucket to steal from, skipping the own bucket
	always_comb begin
		k_next = steal_q ? ({1'b0, scan_q} + 1'b1) : '0;
		if (k_next == {1'b0, bucket_q} && k_next < (KW+1)'(NUM_BUCKETS)) begin
			k_next = k_next + 1'b1;
		end
	end

	// sequencer: next state, RAM controls, working registers
	always_comb begin
		state_d     = state_q;
		req_d       = req_q;
		res_d       = res_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		bucket_d    = bucket_q;
		scan_d      = scan_q;
		steal_d     = steal_q;
		node_d      = node_q;
		link_f_d    = link_f_q;
		link_p_d    = link_p_q;
		first_d     = first_q;
		init_i_d    = init_i_q;
		init_k_d    = init_k_q;
		tag_we      = 1'b0;
		tag_waddr   = BW'(node_q);
		tag_wdata   = {req_q.device_id, req_q.block_number};
		tag_raddr   = BW'(node_q);
		cnt_we      = 1'b0;
		cnt_waddr   = BW'(node_q);
		cnt_wdata   = '0;
		cnt_raddr   = BW'(node_q);
		fwd_we      = 1'b0;
		fwd_waddr   = node_q;
		fwd_wdata   = node_q;
		fwd_raddr   = node_q;
		bwd_we      = 1'b0;
		bwd_waddr   = node_q;
		bwd_wdata   = node_q;
		bwd_raddr   = node_q;
		mod_start   = 1'b0;
		mod_x       = req.block_number;
		req_ready   = 1'b0;

		unique case (state_q)
			// empty rings on every bucket head
			S_INIT_HEAD: begin
				fwd_we    = 1'b1;
				fwd_waddr = head_init;
				fwd_wdata = head_init;
				bwd_we    = 1'b1;
				bwd_waddr = head_init;
				bwd_wdata = head_init;
				if (init_k_q == KW'(NUM_BUCKETS - 1)) begin
					init_k_d = '0;
					init_i_d = '0;
					state_d  = S_INIT_BUF0;
				end else begin
					init_k_d = init_k_q + 1'b1;
				end
			end
			// buffer node links and cleared tag and count
			S_INIT_BUF0: begin
				fwd_we    = 1'b1;
				fwd_waddr = init_i_q;
				fwd_wdata = (init_i_q >= B_NODE) ? init_i_q - B_NODE : head_init;
				bwd_we    = 1'b1;
				bwd_waddr = init_i_q;
				bwd_wdata = (init_i_q + B_NODE < N_NODE) ? init_i_q + B_NODE : head_init;
				tag_we    = 1'b1;
				tag_waddr = BW'(init_i_q);
				tag_wdata = '0;
				cnt_we    = 1'b1;
				cnt_waddr = BW'(init_i_q);
				cnt_wdata = '0;
				state_d   = S_INIT_BUF1;
			end
			// head links for the newest and oldest buffer of the bucket
			S_INIT_BUF1: begin
				fwd_waddr = head_init;
				fwd_wdata = init_i_q;
				fwd_we    = (init_i_q + B_NODE >= N_NODE);
				bwd_waddr = head_init;
				bwd_wdata = init_i_q;
				bwd_we    = (init_i_q < B_NODE);
				if (init_i_q == N_NODE - 1'b1) begin
					state_d = S_IDLE;
				end else begin
					init_i_d = init_i_q + 1'b1;
					init_k_d = (init_k_q == KW'(NUM_BUCKETS - 1)) ? '0 : init_k_q + 1'b1;
					state_d  = S_INIT_BUF0;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					req_d  = req;
					node_d = NW'(req.buffer_index);
					res_d  = '{granted_buffer: '0, needs_read: 1'b0, status: ST_OK};
					if (req.cmd == CMD_GET) begin
						mod_start = 1'b1;
						state_d   = S_GET_MOD;
					end else if (int'(req.buffer_index) < NUM_BUFFERS) begin
						state_d = S_BUF_RD;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_GET_MOD: begin
				fwd_raddr = head_rem;
				if (mod_done) begin
					bucket_d = mod_rem;
					state_d  = S_HIT_FIRST;
				end
			end
			// lookup walk from the head of the own bucket
			S_HIT_FIRST, S_HIT_WALK: begin
				if (state_q == S_HIT_WALK && tag_hit) begin
					res_d.granted_buffer = 5'(node_q);
					if (rc == {CNT_W{1'b1}}) begin
						res_d.status = ST_COUNT;
					end else begin
						cnt_we               = 1'b1;
						cnt_wdata            = {1'b1, rc + 1'b1};
						res_d.needs_read     = !cnt_rdata[CNT_W];
					end
					state_d = S_DONE;
				end else if (fwd_rdata == head_own) begin
					scan_d  = bucket_q;
					steal_d = 1'b0;
					state_d = S_FREE_HEAD;
				end else begin
					node_d    = fwd_rdata;
					tag_raddr = BW'(fwd_rdata);
					cnt_raddr = BW'(fwd_rdata);
					fwd_raddr = fwd_rdata;
					state_d   = S_HIT_WALK;
				end
			end
			S_FREE_HEAD: begin
				bwd_raddr = head_scan;
				state_d   = S_FREE_FIRST;
			end
			// free buffer search from the tail of the scanned bucket
			S_FREE_FIRST, S_FREE_WALK: begin
				if (state_q == S_FREE_WALK && rc == '0) begin
					link_f_d = fwd_rdata;
					link_p_d = bwd_rdata;
					state_d  = steal_q ? S_UNLINK : S_RETAG;
				end else if (bwd_rdata == head_scan) begin
					if (k_next >= (KW+1)'(NUM_BUCKETS)) begin
						res_d.status = ST_NO_FREE;
						state_d      = S_DONE;
					end else begin
						scan_d  = k_next[KW-1:0];
						steal_d = 1'b1;
						state_d = S_FREE_HEAD;
					end
				end else begin
					node_d    = bwd_rdata;
					cnt_raddr = BW'(bwd_rdata);
					fwd_raddr = bwd_rdata;
					bwd_raddr = bwd_rdata;
					state_d   = S_FREE_WALK;
				end
			end
			S_BUF_RD: begin
				state_d = S_BUF_CHK;
			end
			// count update for release, pin and unpin
			S_BUF_CHK: begin
				state_d = S_DONE;
				if (req_q.cmd == CMD_PIN) begin
					if (rc == {CNT_W{1'b1}}) begin
						res_d.status = ST_COUNT;
					end else begin
						cnt_we    = 1'b1;
						cnt_wdata = {cnt_rdata[CNT_W], rc + 1'b1};
					end
				end else if (rc == '0) begin
					res_d.status = ST_COUNT;
				end else begin
					cnt_we    = 1'b1;
					cnt_wdata = {cnt_rdata[CNT_W], rc - 1'b1};
					if (req_q.cmd == CMD_RELEASE && rc == CNT_W'(1)) begin
						link_f_d  = fwd_rdata;
						link_p_d  = bwd_rdata;
						mod_x     = tag_rdata[BLK_W-1:0];
						mod_start = 1'b1;
						state_d   = S_REL_MOD;
					end
				end
			end
			S_REL_MOD: begin
				if (mod_done) begin
					bucket_d = mod_rem;
					state_d  = S_UNLINK;
				end
			end
			S_UNLINK: begin
				fwd_we    = 1'b1;
				fwd_waddr = link_p_q;
				fwd_wdata = link_f_q;
				bwd_we    = 1'b1;
				bwd_waddr = link_f_q;
				bwd_wdata = link_p_q;
				state_d   = S_PUSH_RD;
			end
			S_PUSH_RD: begin
				fwd_raddr = head_own;
				state_d   = S_PUSH_A;
			end
			S_PUSH_A: begin
				first_d   = fwd_rdata;
				fwd_we    = 1'b1;
				fwd_wdata = fwd_rdata;
				bwd_we    = 1'b1;
				bwd_wdata = head_own;
				state_d   = S_PUSH_B;
			end
			S_PUSH_B: begin
				bwd_we    = 1'b1;
				bwd_waddr = first_q;
				bwd_wdata = node_q;
				fwd_we    = 1'b1;
				fwd_waddr = head_own;
				fwd_wdata = node_q;
				state_d   = (req_q.cmd == CMD_GET) ? S_RETAG : S_DONE;
			end
			S_RETAG: begin
				tag_we    = 1'b1;
				cnt_we    = 1'b1;
				cnt_wdata = {1'b1, CNT_W'(1)};
				res_d     = '{granted_buffer: 5'(node_q), needs_read: 1'b1, status: ST_OK};
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_d       = res_q;
					rsp_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT_HEAD;
			rsp_valid_q <= 1'b0;
			init_i_q    <= '0;
			init_k_q    <= '0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
			init_i_q    <= init_i_d;
			init_k_q    <= init_k_d;
		end
	end

	// working payload
	always_ff @(posedge clk) begin
		req_q    <= req_d;
		res_q    <= res_d;
		rsp_q    <= rsp_d;
		bucket_q <= bucket_d;
		scan_q   <= scan_d;
		steal_q  <= steal_d;
		node_q   <= node_d;
		link_f_q <= link_f_d;
		link_p_q <= link_p_d;
		first_q  <= first_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/hbcm_checker.sv]
// hbcm_checker: port-level checks on the hashed block cache manager, bound to the
// top level. Uses hbcm_pkg.
module hbcm_checker
	import hbcm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// a held response keeps its payload until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response dropped or changed while stalled");

	// one request at a time: busy right after an accepted request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// exhausted pool grants nothing
	a_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_NO_FREE |-> rsp.granted_buffer == '0 && !rsp.needs_read)
		else $error("failed get reported a buffer");

	// a count error never asks for a disk read
	a_count_err: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_COUNT |-> !rsp.needs_read)
		else $error("count error with read request");

endmodule

bind hashed_block_cache_manager_core hbcm_checker u_hbcm_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready), .req(req),
	.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);

[verif/hashed_block_cache_manager_core_test.sv]
// Self-checking bench for hashed_block_cache_manager_core: directed and random
// get/release/pin/unpin requests, checked against an in-bench LRU bucket model.
// Depends on rtl/hbcm_pkg.sv and rtl/hashed_block_cache_manager_core.sv.
module hashed_block_cache_manager_core_test;
	import hbcm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBUF = 32;
	localparam int NBKT = 8;
	localparam int NNODE = NBUF + NBKT;
	localparam int RANDOM_REQS = 1400;
	localparam int CYCLE_LIMIT = 1500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	hashed_block_cache_manager_core #(.NUM_BUFFERS(NBUF), .NUM_BUCKETS(NBKT)) DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// cache model state
	logic [DEV_W-1:0] m_dev [NBUF];
	logic [BLK_W-1:0] m_blk [NBUF];
	logic             m_valid [NBUF];
	logic [CNT_W-1:0] m_cnt [NBUF];
	int               fwd [NNODE];
	int               bwd [NNODE];

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int   errors = 0;
	int   checked = 0;
	int   gets = 0, misses_full = 0, steals = 0;
	logic quiet = 1'b0;
	int   cycles = 0;

	function automatic void ring_unlink(int n);
		fwd[bwd[n]] = fwd[n];
		bwd[fwd[n]] = bwd[n];
	endfunction

	function automatic void ring_push(int n, int bkt);
		int h;
		h = NBUF + bkt;
		fwd[n] = fwd[h];
		bwd[n] = h;
		bwd[fwd[h]] = n;
		fwd[h] = n;
	endfunction

	function automatic int oldest_free(int bkt);
		int h;
		int n;
		h = NBUF + bkt;
		n = bwd[h];
		while (n != h) begin
			if (n < NBUF && m_cnt[n] == 0) return n;
			n = bwd[n];
		end
		return -1;
	endfunction

	function automatic void cache_reset();
		for (int i = 0; i < NBUF; i++) begin
			m_dev[i] = '0; m_blk[i] = '0; m_valid[i] = 1'b0; m_cnt[i] = '0;
		end
		for (int k = 0; k < NBKT; k++) begin
			fwd[NBUF + k] = NBUF + k;
			bwd[NBUF + k] = NBUF + k;
		end
		for (int i = 0; i < NBUF; i++) ring_push(i, i % NBKT);
	endfunction

	// apply one request to the model and return its response
	function automatic rsp_t cache_apply(req_t r);
		rsp_t o;
		int bkt;
		int n;
		int hit;
		int b;
		int bi;
		o = '0;
		o.status = ST_OK;
		if (r.cmd == CMD_GET) begin
			gets++;
			bkt = r.block_number % NBKT;
			hit = -1;
			n = fwd[NBUF + bkt];
			while (n != NBUF + bkt) begin
				if (n < NBUF && m_dev[n] == r.device_id && m_blk[n] == r.block_number) begin
					hit = n;
					break;
				end
				n = fwd[n];
			end
			if (hit >= 0) begin
				o.granted_buffer = hit[4:0];
				if (m_cnt[hit] == 8'hFF) o.status = ST_COUNT;
				else begin
					m_cnt[hit]++;
					o.needs_read = !m_valid[hit];
					m_valid[hit] = 1'b1;
				end
			end else begin
				b = oldest_free(bkt);
				for (int k = 0; b < 0 && k < NBKT; k++) begin
					if (k == bkt) continue;
					b = oldest_free(k);
					if (b >= 0) begin
						steals++;
						ring_unlink(b);
						ring_push(b, bkt);
					end
				end
				if (b < 0) begin
					o.status = ST_NO_FREE;
					misses_full++;
				end else begin
					m_dev[b] = r.device_id; m_blk[b] = r.block_number;
					m_cnt[b] = 8'd1; m_valid[b] = 1'b1;
					o.granted_buffer = b[4:0];
					o.needs_read = 1'b1;
				end
			end
		end else begin
			bi = r.buffer_index;
			if (bi < NBUF) begin
				if (r.cmd == CMD_PIN) begin
					if (m_cnt[bi] == 8'hFF) o.status = ST_COUNT;
					else m_cnt[bi]++;
				end else if (m_cnt[bi] == 0) o.status = ST_COUNT;
				else begin
					m_cnt[bi]--;
					if (r.cmd == CMD_RELEASE && m_cnt[bi] == 0) begin
						ring_unlink(bi);
						ring_push(bi, m_blk[bi] % NBKT);
					end
				end
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch #%0d on %s: got %0d, expected %0d", checked, what, got, want);
		errors++;
	endtask

	function automatic req_t make_req(cmd_t c, logic [7:0] d, logic [31:0] blk, logic [4:0] bi);
		req_t r;
		r.cmd = c; r.device_id = d; r.block_number = blk; r.buffer_index = bi;
		return r;
	endfunction

	// request driver with random idle bursts
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				expected_rsps.push_back(cache_apply(req));
				if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 13);
				if (pending_reqs.size() > 0 && (quiet || $urandom_range(0, 5) != 0)) begin
					req <= pending_reqs.pop_front();
				end else req_valid <= 1'b0;
			end else if (!req_valid) begin
				if (send_gap > 0) send_gap <= send_gap - 1;
				else if (pending_reqs.size() > 0) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end
			end
		end
	end

	// response monitor with random stall bursts
	int stall = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				checked++;
				if (expected_rsps.size() == 0) begin
					report_mismatch("response without request", 1, 0);
				end else begin
					rsp_t e;
					e = expected_rsps.pop_front();
					if (rsp.granted_buffer !== e.granted_buffer)
						report_mismatch("granted_buffer", rsp.granted_buffer, e.granted_buffer);
					if (rsp.needs_read !== e.needs_read)
						report_mismatch("needs_read", rsp.needs_read, e.needs_read);
					if (rsp.status !== e.status)
						report_mismatch("status", rsp.status, e.status);
				end
			end
			if (stall > 0) begin
				stall <= stall - 1;
				rsp_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall <= $urandom_range(1, 13);
				rsp_ready <= 1'b0;
			end else rsp_ready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		logic [31:0] blk;
		cache_reset();
		// directed: reset-tag hit, extremes, every command, underflow
		pending_reqs.push_back(make_req(CMD_GET, 8'd0, 32'd0, 5'd0));
		pending_reqs.push_back(make_req(CMD_GET, 8'd0, 32'd0, 5'd31));
		pending_reqs.push_back(make_req(CMD_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0));
		pending_reqs.push_back(make_req(CMD_GET, 8'hAA, 32'h5555_5555, 5'd0));
		pending_reqs.push_back(make_req(CMD_GET, 8'h55, 32'hAAAA_AAAA, 5'h1F));
		pending_reqs.push_back(make_req(CMD_UNPIN, 8'hFF, 32'hFFFF_FFFF, 5'd31));
		pending_reqs.push_back(make_req(CMD_RELEASE, 8'd0, 32'd0, 5'd5));
		pending_reqs.push_back(make_req(CMD_PIN, 8'd0, 32'd0, 5'd5));
		pending_reqs.push_back(make_req(CMD_UNPIN, 8'd0, 32'd0, 5'd5));
		pending_reqs.push_back(make_req(CMD_RELEASE, 8'd0, 32'd0, 5'd0));
		pending_reqs.push_back(make_req(CMD_RELEASE, 8'd0, 32'd0, 5'd0));
		pending_reqs.push_back(make_req(CMD_RELEASE, 8'd0, 32'd0, 5'd0));
		// fill the pool from one bucket to force stealing, then exhaustion
		for (int i = 0; i < 34; i++)
			pending_reqs.push_back(make_req(CMD_GET, 8'd7, 32'(i * NBKT + 3), 5'd0));
		for (int i = 0; i < NBUF; i++)
			pending_reqs.push_back(make_req(CMD_RELEASE, 8'd0, 32'd0, 5'(i)));
		// pin to saturation on one buffer, then overflow on pin
		for (int i = 0; i < 257; i++)
			pending_reqs.push_back(make_req(CMD_PIN, 8'd0, 32'd0, 5'd9));
		pending_reqs.push_back(make_req(CMD_GET, 8'd0, 32'd0, 5'd0));
		for (int i = 0; i < 257; i++)
			pending_reqs.push_back(make_req(CMD_UNPIN, 8'd0, 32'd0, 5'd9));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// random: mostly gets on a small working set, balanced by releases
		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i == RANDOM_REQS * 9 / 10) begin
				wait (pending_reqs.size() == 0);
				quiet = 1'b1;
			end
			while (pending_reqs.size() > 40) @(posedge clk);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					blk = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 60);
					pending_reqs.push_back(make_req(CMD_GET, 8'($urandom_range(0, 3)),
						blk, 5'($urandom)));
				end
				4: pending_reqs.push_back(make_req(CMD_GET, 8'($urandom), $urandom, 5'($urandom)));
				5, 6, 7: pending_reqs.push_back(make_req(CMD_RELEASE, 8'($urandom), $urandom,
					5'($urandom)));
				8: pending_reqs.push_back(make_req(CMD_PIN, 8'($urandom), $urandom, 5'($urandom)));
				default: pending_reqs.push_back(make_req(CMD_UNPIN, 8'($urandom), $urandom,
					5'($urandom)));
			endcase
		end
		wait (pending_reqs.size() == 0 && !req_valid);
		wait (expected_rsps.size() == 0);
		repeat (200) @(posedge clk);
		$display("checked %0d responses: %0d gets, %0d steals, %0d exhausted-pool gets",
			checked, gets, steals, misses_full);
		if (errors == 0 && expected_rsps.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/hbcm_pkg.sv
rtl/hbcm_ram.sv
rtl/hbcm_mod_unit.sv
rtl/hashed_block_cache_manager_core.sv
rtl/hbcm_checker.sv
verif/hashed_block_cache_manager_core_test.sv
